// ===== design/pdt_pkg.sv =====
// Shared types and constants for the pronunciation dictionary tokenizer.
// Holds the character codes, token kind codes and the token record.
// Depends on nothing.
`timescale 1ns / 1ps

package pdt_pkg;

  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam int REPORT_BITS = 32;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    KIND_WORD = 3'd0,
    KIND_CTX  = 3'd1,
    KIND_PRON = 3'd2,
    KIND_ECMT = 3'd3,
    KIND_LCMT = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [REPORT_BITS-1:0]  start_off;
    logic [REPORT_BITS-1:0]  end_off;
  } token_t;

endpackage

// ===== design/pdt_core.sv =====
// Scanner core of the tokenizer: parse state, open token and byte offset.
// Takes one byte per step and reports a closed token. Uses pdt_pkg.
`timescale 1ns / 1ps

module pdt_core #(
  parameter int OFFSET_BITS = pdt_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      byte_value,
  input  logic            new_stream,
  output logic            emit,
  output pdt_pkg::token_t token
);

  typedef enum logic [3:0] {
    ST_START     = 4'd0,
    ST_SEMI1     = 4'd1,
    ST_SEMI2     = 4'd2,
    ST_COMMENT   = 4'd3,
    ST_WORD      = 4'd4,
    ST_CTX_NEXT  = 4'd5,
    ST_CTX       = 4'd6,
    ST_PRON_NEXT = 4'd7,
    ST_PRON      = 4'd8,
    ST_ECMT_NEXT = 4'd9
  } state_t;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);
  localparam logic [OFFSET_BITS-1:0] OFF_TWO = OFFSET_BITS'(2);

  state_t                  state, state_next;
  pdt_pkg::kind_t          kind, kind_next;
  logic [OFFSET_BITS-1:0]  token_start, token_start_next;
  logic [OFFSET_BITS-1:0]  stream_offset, stream_offset_next;

  state_t                  s_open;
  pdt_pkg::kind_t          k_open;
  logic [OFFSET_BITS-1:0]  start_open;
  logic [OFFSET_BITS-1:0]  pos, pos_inc;
  logic                    is_eol, is_blank, emit_c;

  always_comb begin
    s_open     = new_stream ? ST_START : state;
    k_open     = new_stream ? pdt_pkg::KIND_WORD : kind;
    start_open = new_stream ? '0 : token_start;
    pos        = new_stream ? '0 : stream_offset;
    pos_inc    = (pos == OFF_MAX) ? pos : pos + OFF_ONE;
    is_eol     = (byte_value == pdt_pkg::CH_CR) || (byte_value == pdt_pkg::CH_LF);
    is_blank   = (byte_value == pdt_pkg::CH_SPACE) || (byte_value == pdt_pkg::CH_TAB);

    // A token that was announced by the previous delimiter opens at this byte.
    if (s_open == ST_CTX_NEXT) begin
      s_open = ST_CTX; start_open = pos; k_open = pdt_pkg::KIND_CTX;
    end else if (s_open == ST_PRON_NEXT) begin
      s_open = ST_PRON; start_open = pos; k_open = pdt_pkg::KIND_PRON;
    end else if (s_open == ST_ECMT_NEXT) begin
      s_open = ST_COMMENT; start_open = pos; k_open = pdt_pkg::KIND_ECMT;
    end

    state_next       = s_open;
    kind_next        = k_open;
    token_start_next = start_open;
    emit_c           = 1'b0;

    unique case (s_open) inside
      ST_START: begin
        if (byte_value == pdt_pkg::CH_SEMI) begin
          state_next = ST_SEMI1;
        end else if (!(is_blank || is_eol)) begin
          state_next = ST_WORD; token_start_next = pos; kind_next = pdt_pkg::KIND_WORD;
        end
      end
      ST_SEMI1, ST_SEMI2: begin
        if (byte_value == pdt_pkg::CH_SEMI) begin
          if (s_open == ST_SEMI1) begin
            state_next = ST_SEMI2;
          end else begin
            state_next = ST_COMMENT; token_start_next = pos_inc;
            kind_next = pdt_pkg::KIND_LCMT;
          end
        end else if (is_eol) begin
          state_next = ST_START;
        end else begin
          // The headword began at the first semicolon of the line.
          if (s_open == ST_SEMI1) begin
            token_start_next = (pos >= OFF_ONE) ? pos - OFF_ONE : '0;
          end else begin
            token_start_next = (pos >= OFF_TWO) ? pos - OFF_TWO : '0;
          end
          state_next = ST_WORD; kind_next = pdt_pkg::KIND_WORD;
        end
      end
      ST_COMMENT: begin
        if (is_eol) begin
          state_next = ST_START; emit_c = 1'b1;
        end
      end
      ST_WORD: begin
        if (is_blank) begin
          state_next = ST_PRON_NEXT; emit_c = 1'b1;
        end else if (byte_value == pdt_pkg::CH_LPAREN) begin
          state_next = ST_CTX_NEXT; emit_c = 1'b1;
        end else if (is_eol) begin
          state_next = ST_START; emit_c = 1'b1;
        end
      end
      ST_CTX: begin
        if (byte_value == pdt_pkg::CH_RPAREN) begin
          state_next = ST_PRON_NEXT; emit_c = 1'b1;
        end else if (is_eol) begin
          state_next = ST_START;
        end
      end
      ST_PRON: begin
        if (is_eol) begin
          state_next = ST_START; emit_c = 1'b1;
        end else if (byte_value == pdt_pkg::CH_HASH) begin
          state_next = ST_ECMT_NEXT; emit_c = 1'b1;
        end
      end
      default: begin
        state_next = ST_START;
      end
    endcase

    stream_offset_next = pos_inc;
  end

  assign emit            = step && emit_c;
  assign token.kind      = k_open;
  assign token.start_off = pdt_pkg::REPORT_BITS'(start_open);
  assign token.end_off   = pdt_pkg::REPORT_BITS'(pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_START;
      kind          <= pdt_pkg::KIND_WORD;
      token_start   <= '0;
      stream_offset <= '0;
    end else if (step) begin
      state         <= state_next;
      kind          <= kind_next;
      token_start   <= token_start_next;
      stream_offset <= stream_offset_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(state) && $stable(stream_offset) && $stable(token_start))
    else $error("scanner state moved without a byte");

  a_restart_offset: assert property (@(posedge clk) disable iff (rst)
    step && new_stream |=> stream_offset == OFF_ONE)
    else $error("offset not restarted by new_stream");

  a_token_order: assert property (@(posedge clk) disable iff (rst)
    emit |-> start_open <= pos)
    else $error("token closes before it opens");

  a_offset_monotonic: assert property (@(posedge clk) disable iff (rst)
    step && !new_stream |=> stream_offset >= $past(stream_offset))
    else $error("offset went backward within a stream");
`endif

endmodule

// ===== design/pronunciation_dict_tokenizer.sv =====
// Pronunciation dictionary tokenizer, top level: input register, scanner core, result register.
// A held byte passes through the scanner core; a token it closes is stored in the result register.
// Throughput: one byte per cycle; ready drops only while a token waits in a stalled result register.
// Reset (rst, synchronous, active high) returns the scanner to line start with offset zero
// and empties both registers. Uses pdt_pkg and pdt_core.
`timescale 1ns / 1ps

module pronunciation_dict_tokenizer #(
  parameter int OFFSET_BITS = pdt_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       byte_value,
  input  logic                             new_stream,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       token_kind,
  output logic [pdt_pkg::REPORT_BITS-1:0]  begin_offset,
  output logic [pdt_pkg::REPORT_BITS-1:0]  end_offset
);

  // Input register: holds one beat until the scanner consumes it.
  logic        in_held;
  logic [7:0]  byte_q;
  logic        new_stream_q;

  // Result register: holds one token until the consumer takes it.
  pdt_pkg::token_t out_token;

  logic            advance;
  logic            emit;
  pdt_pkg::token_t token;

  // The held byte moves through the scanner whenever the result register
  // is empty or being emptied in this cycle, whether or not the byte closes
  // a token.
  assign advance  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_held <= 1'b1;
    end else if (advance) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q       <= byte_value;
      new_stream_q <= new_stream;
    end
  end

  pdt_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .byte_value(byte_q),
    .new_stream(new_stream_q),
    .emit      (emit),
    .token     (token)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_token <= token;
    end
  end

  assign token_kind   = out_token.kind;
  assign begin_offset = out_token.start_off;
  assign end_offset   = out_token.end_off;

`ifndef SYNTHESIS
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_held && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> !out_valid || out_ready)
    else $error("token would overwrite a pending result");

  a_emit_needs_byte: assert property (@(posedge clk) disable iff (rst)
    emit |-> in_held)
    else $error("token produced without a held byte");
`endif

endmodule
